@@ hdl/msc_pkg.sv @@
// Shared types, constants and helper functions for the scanline concealment map.
// Used by msc_cell and missing_scanline_concealment_map; depends on nothing else.
package msc_pkg;

  // Geometry: luma bitmap split into 64-line words, one word per cell
  localparam int MAX_LINES = 2048;
  localparam int WORD_W    = 64;
  localparam int HALF_W    = WORD_W / 2;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_CELLS = MAX_LINES / WORD_W;
  localparam int CELL_W    = $clog2(NUM_CELLS);
  localparam int CK_W      = CELL_W + 1;
  localparam int LINE_W    = 11;
  localparam int CNT_W     = 12;

  localparam logic [CNT_W-1:0] LUMA_LINES_RESET = 12'd1080;

  typedef enum logic [1:0] {
    MODE_MARK  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    COMP_LUMA     = 2'd0,
    COMP_CHROMA_A = 2'd1,
    COMP_CHROMA_B = 2'd2,
    COMP_NONE     = 2'd3
  } comp_e;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_COPY_PREV = 3'd1,
    ACT_COPY_NEXT = 3'd2,
    ACT_INTERP    = 3'd3,
    ACT_LEAVE_OLD = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [1:0]        component;
    logic [LINE_W-1:0] line_index;
  } msc_in_t;

  typedef struct packed {
    logic              status;
    logic [2:0]        action;
    logic [LINE_W-1:0] prev_line;
    logic [LINE_W-1:0] next_line;
  } msc_out_t;

  // Search candidate passed between neighboring cells
  typedef struct packed {
    logic              found;
    logic [LINE_W-1:0] line;
  } msc_link_t;

  // Query context broadcast to every cell
  typedef struct packed {
    logic [1:0]        comp;
    logic [CELL_W-1:0] qk;        // cell holding the queried line
    logic [BIT_W-1:0]  qb;        // bit of the queried line in that cell
    logic [CK_W-1:0]   ck;        // cell holding the first line past the count
    logic [WORD_W-1:0] lt_mask;   // bits below qb
    logic [WORD_W-1:0] gt_mask;   // bits above qb
    logic [WORD_W-1:0] cnt_mask;  // bits below the count within cell ck
  } msc_query_t;

  typedef struct packed {
    logic mark;
    logic clear;
  } msc_cmd_t;

  // Index of the highest set bit
  function automatic logic [BIT_W-1:0] msb_index(logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // Index of the lowest set bit
  function automatic logic [BIT_W-1:0] lsb_index(logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ hdl/msc_cell.sv @@
// One cell of the concealment map: 64 luma lines and 32 lines of each chroma map.
// Passes the nearest-below candidate up the chain and the nearest-above down.
// Depends on msc_pkg.
module msc_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [msc_pkg::CELL_W-1:0] cell_idx_i,
  input  msc_pkg::msc_query_t        query_i,
  input  msc_pkg::msc_cmd_t          cmd_i,
  input  msc_pkg::msc_link_t         prev_i,
  input  msc_pkg::msc_link_t         next_i,
  output msc_pkg::msc_link_t         prev_o,
  output msc_pkg::msc_link_t         next_o,
  output logic                       hit_o
);

  logic [msc_pkg::WORD_W-1:0] luma_q, luma_d;
  logic [msc_pkg::HALF_W-1:0] cha_q, cha_d;
  logic [msc_pkg::HALF_W-1:0] chb_q, chb_d;

  logic [msc_pkg::WORD_W-1:0] word;
  logic [msc_pkg::WORD_W-1:0] below_mask, above_mask, count_mask;
  logic [msc_pkg::WORD_W-1:0] prev_bits, next_bits;
  logic [msc_pkg::CK_W-1:0]   idx_ext;
  logic [msc_pkg::LINE_W-1:0] base_line;
  logic                       is_luma, own_cell;
  msc_pkg::msc_link_t         prev_q, prev_d, next_q, next_d;

  assign is_luma  = (query_i.comp == msc_pkg::COMP_LUMA);
  assign own_cell = (cell_idx_i == query_i.qk);
  assign idx_ext  = msc_pkg::CK_W'(cell_idx_i);

  // Word of the selected component
  always_comb begin
    case (query_i.comp)
      msc_pkg::COMP_LUMA:     word = luma_q;
      msc_pkg::COMP_CHROMA_A: word = msc_pkg::WORD_W'(cha_q);
      msc_pkg::COMP_CHROMA_B: word = msc_pkg::WORD_W'(chb_q);
      default:                word = '0;
    endcase
  end

  // Region masks relative to the queried line and the line count
  always_comb begin
    if (cell_idx_i < query_i.qk) begin
      below_mask = '1;
      above_mask = '0;
    end else if (own_cell) begin
      below_mask = query_i.lt_mask;
      above_mask = query_i.gt_mask;
    end else begin
      below_mask = '0;
      above_mask = '1;
    end
    if (idx_ext < query_i.ck) begin
      count_mask = '1;
    end else if (idx_ext == query_i.ck) begin
      count_mask = query_i.cnt_mask;
    end else begin
      count_mask = '0;
    end
  end

  assign prev_bits = word & below_mask;
  assign next_bits = word & above_mask & count_mask;
  assign base_line = is_luma ? (msc_pkg::LINE_W'(cell_idx_i) << msc_pkg::BIT_W)
                             : (msc_pkg::LINE_W'(cell_idx_i) << (msc_pkg::BIT_W - 1));

  // Local candidate wins over what the neighbor hands in
  always_comb begin
    if (|prev_bits) begin
      prev_d.found = 1'b1;
      prev_d.line  = base_line | msc_pkg::LINE_W'(msc_pkg::msb_index(prev_bits));
    end else begin
      prev_d = prev_i;
    end
    if (|next_bits) begin
      next_d.found = 1'b1;
      next_d.line  = base_line | msc_pkg::LINE_W'(msc_pkg::lsb_index(next_bits));
    end else begin
      next_d = next_i;
    end
  end

  assign hit_o = own_cell & word[query_i.qb];

  // Bitmap update: clear all, or set one bit
  always_comb begin
    luma_d = luma_q;
    cha_d  = cha_q;
    chb_d  = chb_q;
    if (cmd_i.clear) begin
      luma_d = '0;
      cha_d  = '0;
      chb_d  = '0;
    end else if (cmd_i.mark && own_cell) begin
      case (query_i.comp)
        msc_pkg::COMP_LUMA:     luma_d[query_i.qb] = 1'b1;
        msc_pkg::COMP_CHROMA_A: cha_d[query_i.qb[msc_pkg::BIT_W-2:0]] = 1'b1;
        msc_pkg::COMP_CHROMA_B: chb_d[query_i.qb[msc_pkg::BIT_W-2:0]] = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_q <= '0;
      cha_q  <= '0;
      chb_q  <= '0;
    end else begin
      luma_q <= luma_d;
      cha_q  <= cha_d;
      chb_q  <= chb_d;
    end
  end

  // Chain registers run every cycle; they settle while the query holds
  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    next_q <= next_d;
  end

  assign prev_o = prev_q;
  assign next_o = next_q;

endmodule

@@ hdl/missing_scanline_concealment_map.sv @@
// Scanline concealment map: one received-line bitmap per component (luma and two
// half-height chroma maps) held in a row of 32 cells of 64 luma and 32 chroma lines
// each. A mark, a clear, an out-of-range item or an unused mode passes through the
// EXEC and FINISH states; an in-range concealment query passes through SEARCH too,
// where the nearest received line below hops one cell per cycle up the chain and
// the nearest above hops one cell per cycle down it, so the chain length of 32
// cells sets the search time. One item is in flight at a time; the output register
// lets the next item enter while a result still waits.
// Depends on msc_pkg and msc_cell.
module missing_scanline_concealment_map (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input items
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  msc_pkg::msc_in_t           in_item_i,
  // results
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output msc_pkg::msc_out_t          out_item_o,
  // luma line count register
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [msc_pkg::CNT_W-1:0]  cfg_data_i
);

  msc_pkg::state_e                state_q, state_d;
  logic [msc_pkg::CELL_W-1:0]     srch_cnt_q, srch_cnt_d;
  logic [msc_pkg::CNT_W-1:0]      luma_lines_q;
  msc_pkg::msc_in_t               item_q;
  logic                           in_range_q;
  logic [msc_pkg::CNT_W-1:0]      comp_cnt_q;
  logic                           out_valid_q, out_valid_d;
  msc_pkg::msc_out_t              out_item_q, result;

  logic                           in_accept, out_load;
  logic [msc_pkg::CNT_W-1:0]      luma_cnt, comp_cnt;
  msc_pkg::msc_query_t            query;
  msc_pkg::msc_cmd_t              cmd;
  logic                           is_luma, present, is_query, in_range_d;
  logic [msc_pkg::NUM_CELLS-1:0]  hits;
  msc_pkg::msc_link_t             prev_chain [msc_pkg::NUM_CELLS:0];
  msc_pkg::msc_link_t             next_chain [msc_pkg::NUM_CELLS:0];

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != msc_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Line count of the incoming item's component
  always_comb begin
    luma_cnt = (luma_lines_q > msc_pkg::CNT_W'(msc_pkg::MAX_LINES))
             ? msc_pkg::CNT_W'(msc_pkg::MAX_LINES) : luma_lines_q;
    case (in_item_i.component)
      msc_pkg::COMP_LUMA:     comp_cnt = luma_cnt;
      msc_pkg::COMP_CHROMA_A,
      msc_pkg::COMP_CHROMA_B: comp_cnt = luma_cnt >> 1;
      default:                comp_cnt = '0;
    endcase
    in_range_d = (msc_pkg::CNT_W'(in_item_i.line_index) < comp_cnt);
  end

  // Configuration and item capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_lines_q <= msc_pkg::LUMA_LINES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      luma_lines_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q     <= in_item_i;
      in_range_q <= in_range_d;
      comp_cnt_q <= comp_cnt;
    end
  end

  // Query context broadcast to the cells
  assign is_luma = (item_q.component == msc_pkg::COMP_LUMA);
  always_comb begin
    query.comp = item_q.component;
    if (is_luma) begin
      query.qk = msc_pkg::CELL_W'(item_q.line_index >> msc_pkg::BIT_W);
      query.qb = msc_pkg::BIT_W'(item_q.line_index % msc_pkg::WORD_W);
      query.ck = msc_pkg::CK_W'(comp_cnt_q >> msc_pkg::BIT_W);
      query.cnt_mask = (msc_pkg::WORD_W'(1) << (comp_cnt_q % msc_pkg::WORD_W))
                     - msc_pkg::WORD_W'(1);
    end else begin
      query.qk = msc_pkg::CELL_W'(item_q.line_index >> (msc_pkg::BIT_W - 1));
      query.qb = msc_pkg::BIT_W'(item_q.line_index % msc_pkg::HALF_W);
      query.ck = msc_pkg::CK_W'(comp_cnt_q >> (msc_pkg::BIT_W - 1));
      query.cnt_mask = (msc_pkg::WORD_W'(1) << (comp_cnt_q % msc_pkg::HALF_W))
                     - msc_pkg::WORD_W'(1);
    end
    query.lt_mask = (msc_pkg::WORD_W'(1) << query.qb) - msc_pkg::WORD_W'(1);
    query.gt_mask = ~query.lt_mask & ~(msc_pkg::WORD_W'(1) << query.qb);
  end

  // Cell chain
  assign prev_chain[0]                  = '0;
  assign next_chain[msc_pkg::NUM_CELLS] = '0;

  for (genvar k = 0; k < msc_pkg::NUM_CELLS; k++) begin : g_cell
    msc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (msc_pkg::CELL_W'(k)),
      .query_i    (query),
      .cmd_i      (cmd),
      .prev_i     (prev_chain[k]),
      .next_i     (next_chain[k+1]),
      .prev_o     (prev_chain[k+1]),
      .next_o     (next_chain[k]),
      .hit_o      (hits[k])
    );
  end

  assign present  = |hits;
  assign is_query = (item_q.mode == msc_pkg::MODE_QUERY);

  // Result of the item in hand
  always_comb begin
    result = '0;
    if ((item_q.mode == msc_pkg::MODE_MARK || is_query) && !in_range_q) begin
      result.status = 1'b1;
    end else if (is_query && !present) begin
      if (prev_chain[msc_pkg::NUM_CELLS].found) begin
        result.prev_line = prev_chain[msc_pkg::NUM_CELLS].line;
      end
      if (next_chain[0].found) begin
        result.next_line = next_chain[0].line;
      end
      case ({prev_chain[msc_pkg::NUM_CELLS].found, next_chain[0].found})
        2'b11:   result.action = msc_pkg::ACT_INTERP;
        2'b10:   result.action = msc_pkg::ACT_COPY_PREV;
        2'b01:   result.action = msc_pkg::ACT_COPY_NEXT;
        default: result.action = msc_pkg::ACT_LEAVE_OLD;
      endcase
    end
  end

  // Sequencer: next state, cell commands, output load
  always_comb begin
    state_d    = state_q;
    srch_cnt_d = srch_cnt_q;
    cmd        = '0;
    out_load   = 1'b0;
    case (state_q)
      msc_pkg::ST_IDLE: begin
        if (in_accept) state_d = msc_pkg::ST_EXEC;
      end
      msc_pkg::ST_EXEC: begin
        cmd.clear  = (item_q.mode == msc_pkg::MODE_CLEAR);
        cmd.mark   = (item_q.mode == msc_pkg::MODE_MARK) && in_range_q;
        srch_cnt_d = '0;
        state_d    = (is_query && in_range_q) ? msc_pkg::ST_SEARCH : msc_pkg::ST_FINISH;
      end
      msc_pkg::ST_SEARCH: begin
        srch_cnt_d = srch_cnt_q + 1'b1;
        if (srch_cnt_q == msc_pkg::CELL_W'(msc_pkg::NUM_CELLS - 1)) begin
          state_d = msc_pkg::ST_FINISH;
        end
      end
      msc_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = msc_pkg::ST_IDLE;
        end
      end
      default: state_d = msc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= msc_pkg::ST_IDLE;
      srch_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      srch_cnt_q <= srch_cnt_d;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_item_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("item accepted while another is in flight");

  a_status_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status) |-> (out_item_o.action == msc_pkg::ACT_NONE))
    else $error("out-of-range result carries an action");

  a_no_action_no_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.action == msc_pkg::ACT_NONE)
      |-> (out_item_o.prev_line == '0 && out_item_o.next_line == '0))
    else $error("line numbers reported without an action");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msc_pkg::ST_FINISH && is_query && in_range_q)
      |-> ((!prev_chain[msc_pkg::NUM_CELLS].found
            || prev_chain[msc_pkg::NUM_CELLS].line < item_q.line_index)
        && (!next_chain[0].found || next_chain[0].line > item_q.line_index)))
    else $error("search chain returned a line on the wrong side");

endmodule
